>>> rtl/utf8v_pkg.sv
package utf8v_pkg;

  // Width of the error offset field on the result stream
  localparam int unsigned OUT_OFF_W = 16;

  // Error codes carried in the result beat
  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_LEAD  = 3'd1,
    ERR_CONT  = 3'd2,
    ERR_TRUNC = 3'd3,
    ERR_SURR  = 3'd4
  } err_kind_e;

  // Bit patterns of interest
  localparam logic [7:0] SURR_LEAD = 8'hED;
  localparam logic [7:0] SURR_MASK = 8'hA0;
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_BITS = 8'h80;

  typedef struct packed {
    logic       ok;   // byte is a legal lead
    logic [2:0] rem;  // continuation beats it announces
  } lead_dec_t;

  function automatic lead_dec_t lead_decode(input logic [7:0] b);
    lead_dec_t d;
    d.ok  = 1'b1;
    d.rem = 3'd0;
    case (b) inside
      8'b0???????: d.rem = 3'd0;
      8'b110?????: d.rem = 3'd1;
      8'b1110????: d.rem = 3'd2;
      8'b11110???: d.rem = 3'd3;
      8'b111110??: d.rem = 3'd4;
      8'b1111110?: d.rem = 3'd5;
      default:     d.ok  = 1'b0;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/utf8_stream_validator_top.sv
// UTF-8 stream checker: one byte per beat in, one verdict per string out.
// The final byte is held in the input register, then its verdict is loaded
//   into the result register.
// Throughput: one byte per cycle; a final byte waits while the verdict output stalls.
// Reset (rst_ni low, asynchronous): string state cleared, both streams empty.
module utf8_stream_validator_top #(
  parameter int unsigned OFFSET_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte stream in
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // end_of_string
  // Verdict stream out
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [0] is_valid, [3:1] error_kind,
                                        // [19:4] error_offset, [23:20] zero
);
  import utf8v_pkg::*;

  localparam logic [OFFSET_WIDTH-1:0] OffMax = '1;

  // Input register: one byte waiting to be checked
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // String state
  logic [2:0]              rem_q, rem_d;
  logic                    pend_q, pend_d;
  err_kind_e               err_q, err_d;
  logic [OFFSET_WIDTH-1:0] off_q, off_d;
  logic [OFFSET_WIDTH-1:0] pos_q, pos_d;

  // Result register
  logic                 out_vld_q;
  logic                 out_ok_q, out_ok_d;
  err_kind_e            out_kind_q, out_kind_d;
  logic [OUT_OFF_W-1:0] out_off_q, out_off_d;

  logic      out_free;
  logic      advance;
  lead_dec_t lead;
  err_kind_e err_step;
  logic [2:0] rem_step;
  logic [OUT_OFF_W-1:0] pos_out;

  // A non-final byte never needs the result register; a final one waits for it.
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign advance         = in_vld_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_vld_q || advance;

  assign lead = lead_decode(in_byte_q);

  // Per-byte check; once an error is held, bytes are only counted
  always_comb begin
    err_step = err_q;
    rem_step = rem_q;
    pend_d   = 1'b0;
    pos_d    = pos_q;
    if (err_q == ERR_NONE) begin
      if (pend_q && ((in_byte_q & SURR_MASK) == SURR_MASK)) begin
        err_step = ERR_SURR;
      end else if (rem_q != 3'd0) begin
        if ((in_byte_q & CONT_MASK) != CONT_BITS) begin
          err_step = ERR_CONT;
        end else begin
          rem_step = rem_q - 3'd1;
        end
      end else if (lead.ok) begin
        rem_step = lead.rem;
        pend_d   = (in_byte_q == SURR_LEAD);
      end else begin
        err_step = ERR_LEAD;
      end
      // string ends mid-sequence
      if (in_last_q && err_step == ERR_NONE && rem_step != 3'd0) begin
        err_step = ERR_TRUNC;
      end
      if (err_step != ERR_NONE) begin
        pos_d = off_q;
      end
    end
    err_d = err_step;
    rem_d = rem_step;
  end

  generate
    if (OFFSET_WIDTH > OUT_OFF_W) begin : g_sat
      assign pos_out = (pos_d > OFFSET_WIDTH'({OUT_OFF_W{1'b1}})) ?
                       '1 : pos_d[OUT_OFF_W-1:0];
    end else begin : g_ext
      assign pos_out = OUT_OFF_W'(pos_d);
    end
  endgenerate

  always_comb begin
    out_ok_d   = (err_d == ERR_NONE);
    out_kind_d = err_d;
    out_off_d  = (err_d == ERR_NONE) ? '0 : pos_out;
    off_d      = (off_q < OffMax) ? off_q + OFFSET_WIDTH'(1) : off_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // State: cleared after each final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      pend_q <= 1'b0;
      err_q  <= ERR_NONE;
      off_q  <= '0;
      pos_q  <= '0;
    end else if (advance) begin
      if (in_last_q) begin
        rem_q  <= '0;
        pend_q <= 1'b0;
        err_q  <= ERR_NONE;
        off_q  <= '0;
        pos_q  <= '0;
      end else begin
        rem_q  <= rem_d;
        pend_q <= pend_d;
        err_q  <= err_d;
        off_q  <= off_d;
        pos_q  <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= advance && in_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_ok_q   <= out_ok_d;
      out_kind_q <= out_kind_d;
      out_off_q  <= out_off_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'b0000, out_off_q, out_kind_q, out_ok_q};

`ifndef ASSERT_OFF
  // verdict bit agrees with the error code
  a_ok_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_ok_q == (out_kind_q == ERR_NONE)))
    else $error("verdict disagrees with error kind");

  // a clean string reports offset zero
  a_ok_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_ok_q) |-> (out_off_q == '0))
    else $error("non-zero offset on a valid string");

  // error position only moves once an error is held
  a_pos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q == ERR_NONE) |-> (pos_q == '0))
    else $error("error position set without an error");

  // a pending surrogate check only follows a clean 0xED lead
  a_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (rem_q == 3'd2 && err_q == ERR_NONE))
    else $error("surrogate mark without a three-byte lead");

  // no lead announces more than five continuation bytes
  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= 3'd5)
    else $error("continuation count out of range");
`endif

endmodule

>>> verif/tb_utf8_stream_validator_top.sv
`timescale 1ns / 100ps

module tb_utf8_stream_validator_top;
  import utf8v_pkg::*;

  localparam int unsigned HOLD_CYCLES = 400;     // long output hold-off
  localparam int unsigned LIMIT       = 600_000; // hard stop, cycles
  localparam int unsigned TAIL_CYCLES = 20;      // settle time after the last verdict

  typedef logic [7:0] octets_t[$];

  typedef struct packed {
    logic [7:0] octet;
    logic       last;
  } text_beat_t;

  typedef struct packed {
    logic        ok;
    err_kind_e   kind;
    logic [15:0] off;
  } verdict_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  // Stimulus and expectation stores
  text_beat_t  beats_pending[$];
  verdict_t    verdicts_due[$];
  text_beat_t  nxt_beat;

  // Idle mix for the current phase, in percent
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  logic        holdoff_go   = 1'b0;
  logic        hold_rx      = 1'b0;

  // Checker model state
  logic [2:0]  cont_left = 3'd0;
  logic        after_ed  = 1'b0;
  err_kind_e   err_seen  = ERR_NONE;
  logic [15:0] cur_off   = 16'd0;
  logic [15:0] err_pos   = 16'd0;

  int unsigned mismatches  = 0;
  int unsigned checked     = 0;
  int unsigned bytes_taken = 0;
  int unsigned cycles      = 0;
  int unsigned kind_tally[5];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  utf8_stream_validator_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  // ---------------------------------------------------------------------------
  // Model of the checker, stepped once per accepted input beat
  // ---------------------------------------------------------------------------

  // Sticky: only the first error of a string is kept.
  task automatic flag_error(input err_kind_e k, input logic [15:0] pos);
    if (err_seen == ERR_NONE) begin
      err_seen = k;
      err_pos  = pos;
    end
  endtask

  task automatic take_byte(input logic [7:0] b, input logic last);
    logic [15:0] pos;
    logic        was_ed;
    verdict_t    v;
    pos      = cur_off;
    was_ed   = after_ed;
    after_ed = 1'b0;
    bytes_taken++;
    if (err_seen == ERR_NONE) begin
      // surrogate test wins over the continuation test on the byte after 0xED
      if (was_ed && ((b & SURR_MASK) == SURR_MASK)) begin
        flag_error(ERR_SURR, pos);
      end else if (cont_left != 3'd0) begin
        if ((b & CONT_MASK) != CONT_BITS) flag_error(ERR_CONT, pos);
        else cont_left = cont_left - 3'd1;
      end else if (b[7] == 1'b0) begin
        cont_left = 3'd0;
      end else if (b[7:5] == 3'b110) begin
        cont_left = 3'd1;
      end else if (b[7:4] == 4'b1110) begin
        cont_left = 3'd2;
        after_ed  = (b == SURR_LEAD);
      end else if (b[7:3] == 5'b11110) begin
        cont_left = 3'd3;
      end else if (b[7:2] == 6'b111110) begin
        cont_left = 3'd4;
      end else if (b[7:1] == 7'b1111110) begin
        cont_left = 3'd5;
      end else begin
        flag_error(ERR_LEAD, pos);
      end
    end
    if (!last) begin
      if (cur_off != 16'hFFFF) cur_off = cur_off + 16'd1;  // saturates
    end else begin
      if (err_seen == ERR_NONE && cont_left != 3'd0) flag_error(ERR_TRUNC, pos);
      v.ok   = (err_seen == ERR_NONE);
      v.kind = err_seen;
      v.off  = v.ok ? 16'd0 : err_pos;
      verdicts_due.insert(verdicts_due.size(), v);
      kind_tally[err_seen]++;
      cont_left = 3'd0;
      after_ed  = 1'b0;
      err_seen  = ERR_NONE;
      cur_off   = 16'd0;
      err_pos   = 16'd0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Comparison of verdict beats
  // ---------------------------------------------------------------------------

  task automatic log_mismatch(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0d at verdict %0d: %s expected %0h got %0h",
               mismatches, checked, what, want, got);
  endtask

  // tdata: [0] is_valid, [3:1] error_kind, [19:4] error_offset, [23:20] zero
  task automatic check_verdict(input logic [23:0] d);
    verdict_t want;
    if (verdicts_due.size() == 0) begin
      log_mismatch("verdict with none pending", 32'd0, {8'd0, d});
      return;
    end
    want = verdicts_due.pop_front();
    checked++;
    if (d[0] !== want.ok)     log_mismatch("is_valid", 32'(want.ok), 32'(d[0]));
    if (d[3:1] !== want.kind) log_mismatch("error_kind", 32'(want.kind), 32'(d[3:1]));
    if (d[19:4] !== want.off) log_mismatch("error_offset", 32'(want.off), 32'(d[19:4]));
    if (d[23:20] !== 4'd0)    log_mismatch("padding", 32'd0, 32'(d[23:20]));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: pops pending beats, holds each until taken, idles at random
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
      s_tlast  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) take_byte(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (beats_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt_beat = beats_pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nxt_beat.octet;
          s_tlast  <= nxt_beat.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, plus the long hold-off when asked
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !hold_rx && ($urandom_range(99) >= rx_stall_pct);
      if (m_tvalid && m_tready) check_verdict(m_tdata);
    end
  end

  // Output hold-off, counted here so the sender keeps offering beats meanwhile
  initial begin
    wait (holdoff_go);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding",
               cycles, verdicts_due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic send_text(input octets_t s);
    text_beat_t tb;
    foreach (s[i]) begin
      tb.octet = s[i];
      tb.last  = (i == s.size() - 1);
      beats_pending.insert(beats_pending.size(), tb);
    end
  endtask

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  // Mostly well-formed text with random content; a share is corrupted.
  task automatic make_text(output octets_t s);
    int unsigned n_chars;
    int unsigned k;
    logic [7:0]  ones;
    s = {};
    n_chars = ($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
    repeat (n_chars) begin
      case ($urandom_range(9))
        0, 1, 2: s.insert(s.size(), 8'($urandom_range(127)));
        5: begin
          // 0xED lead: second byte decides surrogate or not
          s.insert(s.size(), SURR_LEAD);
          s.insert(s.size(), ($urandom_range(3) == 0) ? 8'($urandom) : cont_byte());
          s.insert(s.size(), cont_byte());
        end
        9: s.insert(s.size(), 8'($urandom));
        default: begin
          // multi-byte form with 1 to 5 continuation beats
          k    = $urandom_range(1, 5);
          ones = 8'hFF << (7 - k);
          s.insert(s.size(), ones | (8'($urandom) & (8'hFF >> (k + 2))));
          repeat (k) s.insert(s.size(), cont_byte());
        end
      endcase
    end
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0: s[$urandom_range(s.size() - 1)] = 8'($urandom);
        1: if (s.size() > 1) void'(s.pop_back());
        2: s.insert($urandom_range(s.size()), $urandom_range(1) ? 8'hFE : 8'hFF);
        default: s[$urandom_range(s.size() - 1)] = {2'b11, 6'($urandom)};
      endcase
    end
  endtask

  // Drained once nothing is queued, in flight or awaited.
  task automatic wait_idle();
    while (beats_pending.size() != 0 || s_tvalid || verdicts_due.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic run_phase(input int unsigned tx, input int unsigned rx,
                           input int unsigned n_bytes);
    octets_t     txt;
    int unsigned sent;
    sent         = 0;
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    while (sent < n_bytes) begin
      make_text(txt);
      send_text(txt);
      sent += txt.size();
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    octets_t    txt;
    foreach (kind_tally[i]) kind_tally[i] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: plain and extreme bytes, every error kind, surrogate edges.
    txt = {8'h00};                                     send_text(txt); // zero byte
    txt = {8'h7F};                                     send_text(txt);
    txt = {8'hFF};                                     send_text(txt); // bad lead
    txt = {8'hFE};                                     send_text(txt);
    txt = {8'hED, 8'hA0, 8'h80};                       send_text(txt); // surrogate
    txt = {8'hED, 8'h9F, 8'hBF};                       send_text(txt); // 0xED, legal
    txt = {8'hE2, 8'h41};                              send_text(txt); // bad cont
    txt = {8'hF0, 8'h90, 8'h80};                       send_text(txt); // truncated
    txt = {8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};  send_text(txt); // 6-byte form
    txt = {8'h80, 8'hC0};                              send_text(txt); // error sticks
    txt = {8'hED};                                     send_text(txt); // lone 0xED
    wait_idle();

    // No idling, with the long hold-off at the start so the input backs up.
    holdoff_go = 1'b1;
    run_phase(0, 0, 225);

    run_phase(78, 0, 225);
    run_phase(0, 78, 225);
    run_phase(24, 24, 225);

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (verdicts_due.size() != 0)
      log_mismatch("verdicts never seen", 32'd0, 32'(verdicts_due.size()));

    $display("Run: %0d bytes, %0d verdicts checked (%0d valid, %0d bad lead, %0d bad cont,",
             bytes_taken, checked, kind_tally[ERR_NONE], kind_tally[ERR_LEAD],
             kind_tally[ERR_CONT]);
    $display("  %0d truncated, %0d surrogate); four idle mixes plus a long output hold-off",
             kind_tally[ERR_TRUNC], kind_tally[ERR_SURR]);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> utf8_stream_validator_top.f
rtl/utf8v_pkg.sv
rtl/utf8_stream_validator_top.sv
verif/tb_utf8_stream_validator_top.sv
